>>> design/alrle_pkg.sv
package alrle_pkg;

  localparam int RUN_W    = 5;
  localparam int TOTAL_W  = 6;
  localparam int LEVEL_W  = 3;
  localparam int OFFSET_W = 18;
  localparam int RGB_W    = 16;

  localparam logic [7:0] ALPHA_LEVEL1_MIN = 8'd32;
  localparam logic [7:0] ALPHA_LEVEL1_MAX = 8'd95;
  localparam logic [7:0] ALPHA_LEVEL2_MAX = 8'd159;
  localparam logic [7:0] ALPHA_LEVEL3_MAX = 8'd223;
  localparam logic [7:0] ALPHA_LEVEL0_MAX = 8'd31;

  localparam int LEVEL_SHIFT = 13;
  localparam int RED_POS     = 11;
  localparam int GREEN_POS   = 5;

  localparam logic [1:0] REG_ROW_WIDTH  = 2'd0;
  localparam logic [1:0] REG_KEY_ENABLE = 2'd1;
  localparam logic [1:0] REG_KEY_COLOUR = 2'd2;

  localparam logic [15:0] ROW_WIDTH_RESET = 16'd320;

  typedef struct packed {
    logic [15:0]      row_width;
    logic             key_enable;
    logic [RGB_W-1:0] key_colour;
    logic             restart;
    logic [15:0]      new_width;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [RUN_W-1:0]   len;
  } run_entry_t;

  typedef struct packed {
    logic                bank;
    logic [RUN_W-1:0]    runs;
    logic [TOTAL_W-1:0]  total;
    logic [OFFSET_W-1:0] offset;
  } desc_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } release_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_COUNT,
    BK_HEADER,
    BK_WAIT,
    BK_COLOUR
  } back_state_t;

  typedef enum logic [1:0] {
    WK_COUNT,
    WK_HEADER,
    WK_COLOUR
  } word_kind_t;

  function automatic logic [RGB_W-1:0] rgb565(input logic [31:0] abgr);
    logic [RGB_W-1:0] r;
    logic [RGB_W-1:0] g;
    logic [RGB_W-1:0] b;
    r = RGB_W'(abgr[7:3]);
    g = RGB_W'(abgr[15:10]);
    b = RGB_W'(abgr[23:19]);
    rgb565 = (r << RED_POS) | (g << GREEN_POS) | b;
  endfunction

  function automatic logic [LEVEL_W-1:0] alpha_level(input logic [7:0] a);
    priority if (a <= ALPHA_LEVEL0_MAX) alpha_level = LEVEL_W'(0);
    else if (a <= ALPHA_LEVEL1_MAX)      alpha_level = LEVEL_W'(1);
    else if (a <= ALPHA_LEVEL2_MAX)      alpha_level = LEVEL_W'(2);
    else if (a <= ALPHA_LEVEL3_MAX)      alpha_level = LEVEL_W'(3);
    else                                 alpha_level = LEVEL_W'(4);
  endfunction

endpackage

>>> design/alrle_if.sv
interface alrle_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_abgr;

  modport source(output valid, output pixel_abgr, input ready);
  modport sink(input valid, input pixel_abgr, output ready);
endinterface

interface alrle_word_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_word;
  logic [17:0] segment_offset;
  logic [31:0] coloured_total;
  logic        segment_last;

  modport source(output valid, output code_word, output segment_offset,
                 output coloured_total, output segment_last, input ready);
  modport sink(input valid, input code_word, input segment_offset,
               input coloured_total, input segment_last, output ready);
endinterface

>>> design/alrle_ram.sv
module alrle_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/alrle_front.sv
module alrle_front #(
  parameter int SEGMENT_WIDTH = 16,
  parameter int AW = $clog2(2 * SEGMENT_WIDTH)
) (
  input  logic                      clk,
  input  logic                      rst,
  alrle_pixel_if.sink               pixels,
  input  alrle_pkg::cfg_t           cfg,
  input  alrle_pkg::release_t       rel,
  output alrle_pkg::desc_t          desc,
  output logic                      desc_push,
  output logic                      pix_we,
  output logic [AW-1:0]             pix_waddr,
  output logic [alrle_pkg::RGB_W-1:0] pix_wdata,
  output logic                      run_we,
  output logic [AW-1:0]             run_waddr,
  output alrle_pkg::run_entry_t     run_wdata
);

  localparam int FW = $clog2(SEGMENT_WIDTH + 1);
  localparam int IW = (SEGMENT_WIDTH > 1) ? $clog2(SEGMENT_WIDTH) : 1;
  localparam int RECIP_SHIFT = 22;
  localparam logic [22:0] RECIP =
    23'((2 ** RECIP_SHIFT + SEGMENT_WIDTH - 1) / SEGMENT_WIDTH);

  // ceil(width / SEGMENT_WIDTH) by reciprocal multiply, exact for 17-bit dividends
  function automatic logic [15:0] col_count_of(input logic [15:0] w);
    logic [16:0] x;
    logic [39:0] prod;
    x = ((w == 16'd0) ? 17'd1 : {1'b0, w}) + 17'(SEGMENT_WIDTH - 1);
    prod = x * RECIP;
    col_count_of = prod[RECIP_SHIFT+15:RECIP_SHIFT];
  endfunction

  function automatic logic [AW-1:0] bank_addr(input logic bank, input logic [IW-1:0] idx);
    bank_addr = bank ? (AW'(SEGMENT_WIDTH) + AW'(idx)) : AW'(idx);
  endfunction

  logic [FW-1:0]                     fill;
  logic [alrle_pkg::RUN_W-1:0]       runs;
  logic [alrle_pkg::RUN_W-1:0]       ncol;
  logic [alrle_pkg::RUN_W-1:0]       cur_len;
  logic [alrle_pkg::LEVEL_W-1:0]     prev_level;
  logic [15:0]                       row_pos;
  logic [alrle_pkg::OFFSET_W-1:0]    row_acc;
  logic [15:0]                       col_count;
  logic                              wbank;
  logic [1:0]                        busy;
  logic [1:0]                        busy_next;

  logic [alrle_pkg::RGB_W-1:0]       rgb;
  logic                              keyed;
  logic [alrle_pkg::LEVEL_W-1:0]     level;
  logic                              accept;
  logic                              first;
  logic                              new_run;
  logic [alrle_pkg::RUN_W-1:0]       run_slot;
  logic [alrle_pkg::RUN_W-1:0]       runs_next;
  logic [alrle_pkg::RUN_W-1:0]       len_next;
  logic [alrle_pkg::RUN_W-1:0]       ncol_next;
  logic [FW-1:0]                     fill_next;
  logic [16:0]                       pos_next;
  logic [16:0]                       eff_width;
  logic                              row_end;
  logic                              close;
  logic [alrle_pkg::TOTAL_W-1:0]     total;

  assign pixels.ready = !busy[wbank];
  assign accept = pixels.valid && pixels.ready;

  always_comb begin
    rgb   = alrle_pkg::rgb565(pixels.pixel_abgr);
    keyed = cfg.key_enable && (rgb == cfg.key_colour);
    level = keyed ? '0 : alrle_pkg::alpha_level(pixels.pixel_abgr[31:24]);
    first = (fill == '0);
    new_run = first || (level != prev_level);
    if (first) begin
      run_slot = '0;
    end else if (new_run) begin
      run_slot = runs;
    end else begin
      run_slot = runs - 1'b1;
    end
    runs_next = run_slot + 1'b1;
    len_next  = new_run ? alrle_pkg::RUN_W'(1) : cur_len + 1'b1;
    ncol_next = (first ? '0 : ncol) + alrle_pkg::RUN_W'(level != '0);
    fill_next = fill + 1'b1;
    pos_next  = {1'b0, row_pos} + 17'd1;
    eff_width = (cfg.row_width == 16'd0) ? 17'd1 : {1'b0, cfg.row_width};
    row_end   = (pos_next >= eff_width);
    close     = accept && ((fill_next == FW'(SEGMENT_WIDTH)) || row_end);
    total     = alrle_pkg::TOTAL_W'(1) + alrle_pkg::TOTAL_W'(runs_next)
              + alrle_pkg::TOTAL_W'(ncol_next);
  end

  always_comb begin
    pix_we          = accept;
    pix_waddr       = bank_addr(wbank, fill[IW-1:0]);
    pix_wdata       = keyed ? '0 : rgb;
    run_we          = accept;
    run_waddr       = bank_addr(wbank, run_slot[IW-1:0]);
    run_wdata.level = level;
    run_wdata.len   = len_next;
    desc_push       = close;
    desc.bank       = wbank;
    desc.runs       = runs_next;
    desc.total      = total;
    desc.offset     = alrle_pkg::OFFSET_W'(col_count) + row_acc;
  end

  always_comb begin
    busy_next = busy;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (close) begin
      busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill      <= '0;
      runs      <= '0;
      ncol      <= '0;
      row_pos   <= '0;
      row_acc   <= '0;
      col_count <= col_count_of(alrle_pkg::ROW_WIDTH_RESET);
      wbank     <= 1'b0;
      busy      <= '0;
    end else begin
      busy <= busy_next;
      if (cfg.restart) begin
        // restart the row: drop a partly gathered segment
        fill      <= '0;
        row_pos   <= '0;
        row_acc   <= '0;
        col_count <= col_count_of(cfg.new_width);
      end else if (accept) begin
        runs <= runs_next;
        ncol <= ncol_next;
        if (close) begin
          fill  <= '0;
          wbank <= !wbank;
          if (row_end) begin
            row_pos <= '0;
            row_acc <= '0;
          end else begin
            row_pos <= pos_next[15:0];
            row_acc <= row_acc + alrle_pkg::OFFSET_W'(total);
          end
        end else begin
          fill    <= fill_next;
          row_pos <= pos_next[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_level <= level;
      cur_len    <= len_next;
    end
  end

endmodule

>>> design/alrle_desc_queue.sv
module alrle_desc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  alrle_pkg::desc_t din,
  input  logic             pop,
  output alrle_pkg::desc_t dout,
  output logic             empty
);

  alrle_pkg::desc_t entry [2];
  logic             wptr;
  logic             rptr;
  logic [1:0]       count;

  assign dout  = entry[rptr];
  assign empty = (count == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= din;
    end
  end

endmodule

>>> design/alrle_back.sv
module alrle_back #(
  parameter int SEGMENT_WIDTH = 16,
  parameter int AW = $clog2(2 * SEGMENT_WIDTH)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  alrle_pkg::desc_t            desc,
  input  logic                        desc_empty,
  output logic                        desc_pop,
  output alrle_pkg::release_t         rel,
  output logic                        rd_en,
  output logic [AW-1:0]               pix_raddr,
  output logic [AW-1:0]               run_raddr,
  input  logic [alrle_pkg::RGB_W-1:0] pix_rdata,
  input  alrle_pkg::run_entry_t       run_rdata,
  alrle_word_if.source                words
);

  localparam int IW = (SEGMENT_WIDTH > 1) ? $clog2(SEGMENT_WIDTH) : 1;

  function automatic logic [AW-1:0] bank_addr(input logic bank, input logic [IW-1:0] idx);
    bank_addr = bank ? (AW'(SEGMENT_WIDTH) + AW'(idx)) : AW'(idx);
  endfunction

  alrle_pkg::back_state_t st, st_next;

  logic                             bank, bank_next;
  logic [alrle_pkg::RUN_W-1:0]      run_count, run_count_next;
  logic [alrle_pkg::RUN_W-1:0]      runs_left, runs_left_next;
  logic [alrle_pkg::TOTAL_W-1:0]    words_left, words_left_next;
  logic [IW-1:0]                    pix_idx, pix_idx_next;
  logic [IW-1:0]                    run_idx, run_idx_next;
  logic [alrle_pkg::RUN_W-1:0]      col_left, col_left_next;
  logic [alrle_pkg::OFFSET_W-1:0]   offset, offset_next;
  logic [31:0]                      count, count_next;

  logic                             issue;
  alrle_pkg::word_kind_t            issue_kind;
  logic [31:0]                      issue_total;
  logic                             slot_free;

  logic                             b_valid;
  alrle_pkg::word_kind_t            b_kind;
  logic                             b_last;
  logic [alrle_pkg::OFFSET_W-1:0]   b_offset;
  logic [31:0]                      b_total;
  logic [alrle_pkg::RUN_W-1:0]      b_imm;
  logic [15:0]                      b_word;

  logic                             c_valid;
  logic                             c_load;

  assign c_load    = b_valid && (!c_valid || words.ready);
  assign slot_free = !b_valid || c_load;

  always_comb begin
    st_next         = st;
    bank_next       = bank;
    run_count_next  = run_count;
    runs_left_next  = runs_left;
    words_left_next = words_left;
    pix_idx_next    = pix_idx;
    run_idx_next    = run_idx;
    col_left_next   = col_left;
    offset_next     = offset;
    count_next      = count;
    issue           = 1'b0;
    issue_kind      = alrle_pkg::WK_COUNT;
    issue_total     = count;
    desc_pop        = 1'b0;
    rel.valid       = 1'b0;
    rel.bank        = bank;
    unique case (st)
      alrle_pkg::BK_IDLE: begin
        if (!desc_empty) begin
          desc_pop        = 1'b1;
          bank_next       = desc.bank;
          run_count_next  = desc.runs;
          runs_left_next  = desc.runs;
          words_left_next = desc.total;
          offset_next     = desc.offset;
          pix_idx_next    = '0;
          run_idx_next    = '0;
          st_next         = alrle_pkg::BK_COUNT;
        end
      end
      alrle_pkg::BK_COUNT: begin
        if (slot_free) begin
          issue           = 1'b1;
          issue_kind      = alrle_pkg::WK_COUNT;
          words_left_next = words_left - 1'b1;
          st_next         = alrle_pkg::BK_HEADER;
        end
      end
      alrle_pkg::BK_HEADER: begin
        if (slot_free) begin
          issue           = 1'b1;
          issue_kind      = alrle_pkg::WK_HEADER;
          words_left_next = words_left - 1'b1;
          runs_left_next  = runs_left - 1'b1;
          run_idx_next    = run_idx + 1'b1;
          st_next         = alrle_pkg::BK_WAIT;
        end
      end
      alrle_pkg::BK_WAIT: begin
        // header entry sits in the read register; decide on its colours
        if (run_rdata.level != '0) begin
          col_left_next = run_rdata.len;
          st_next       = alrle_pkg::BK_COLOUR;
        end else begin
          pix_idx_next = pix_idx + IW'(run_rdata.len);
          if (runs_left == '0) begin
            rel.valid = 1'b1;
            st_next   = alrle_pkg::BK_IDLE;
          end else begin
            st_next = alrle_pkg::BK_HEADER;
          end
        end
      end
      alrle_pkg::BK_COLOUR: begin
        if (slot_free) begin
          issue           = 1'b1;
          issue_kind      = alrle_pkg::WK_COLOUR;
          count_next      = (count == '1) ? count : count + 32'd1;
          issue_total     = count_next;
          words_left_next = words_left - 1'b1;
          pix_idx_next    = pix_idx + 1'b1;
          col_left_next   = col_left - 1'b1;
          if (col_left == alrle_pkg::RUN_W'(1)) begin
            if (runs_left == '0) begin
              rel.valid = 1'b1;
              st_next   = alrle_pkg::BK_IDLE;
            end else begin
              st_next = alrle_pkg::BK_HEADER;
            end
          end
        end
      end
      default: begin
        st_next = alrle_pkg::BK_IDLE;
      end
    endcase
  end

  assign rd_en     = issue;
  assign pix_raddr = bank_addr(bank, pix_idx);
  assign run_raddr = bank_addr(bank, run_idx);

  always_comb begin
    unique case (b_kind)
      alrle_pkg::WK_COUNT:  b_word = 16'(b_imm);
      alrle_pkg::WK_HEADER: b_word = (16'(run_rdata.level) << alrle_pkg::LEVEL_SHIFT)
                                   | 16'(run_rdata.len);
      alrle_pkg::WK_COLOUR: b_word = pix_rdata;
      default:              b_word = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= alrle_pkg::BK_IDLE;
      count   <= '0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      st    <= st_next;
      count <= count_next;
      if (issue) begin
        b_valid <= 1'b1;
      end else if (c_load) begin
        b_valid <= 1'b0;
      end
      if (c_load) begin
        c_valid <= 1'b1;
      end else if (words.ready) begin
        c_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    bank       <= bank_next;
    run_count  <= run_count_next;
    runs_left  <= runs_left_next;
    words_left <= words_left_next;
    pix_idx    <= pix_idx_next;
    run_idx    <= run_idx_next;
    col_left   <= col_left_next;
    offset     <= offset_next;
    if (issue) begin
      b_kind   <= issue_kind;
      b_last   <= (words_left == alrle_pkg::TOTAL_W'(1));
      b_offset <= offset;
      b_total  <= issue_total;
      b_imm    <= run_count;
    end
    if (c_load) begin
      words.code_word      <= b_word;
      words.segment_offset <= b_offset;
      words.coloured_total <= b_total;
      words.segment_last   <= b_last;
    end
  end

  assign words.valid = c_valid;

endmodule

>>> design/alpha_level_run_length_encoder_top.sv
// Intake: one pixel per cycle while the segment bank being filled is not busy.
// Output: a segment with r runs and c coloured pixels gives 1 + r + c words; the back
// end also spends a descriptor fetch state and a read-wait state per run header.
// A segment's first word passes the descriptor queue, BK_COUNT, then registers b and c.
// Reset (rst, synchronous): row_width 320, keying off, empty queue, count zero;
// segment banks are not cleared.
module alpha_level_run_length_encoder_top #(
  parameter int SEGMENT_WIDTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  alrle_pixel_if.sink  pixels,
  alrle_word_if.source words,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int DEPTH = 2 * SEGMENT_WIDTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [15:0]                 row_width;
  logic                        key_enable;
  logic [alrle_pkg::RGB_W-1:0] key_colour;
  logic                        cfg_write;
  logic [1:0]                  cfg_sel;
  alrle_pkg::cfg_t             cfg;

  alrle_pkg::desc_t            desc_in;
  alrle_pkg::desc_t            desc_out;
  logic                        desc_push;
  logic                        desc_pop;
  logic                        desc_empty;
  alrle_pkg::release_t         rel;

  logic                        pix_we;
  logic [AW-1:0]               pix_waddr;
  logic [alrle_pkg::RGB_W-1:0] pix_wdata;
  logic                        run_we;
  logic [AW-1:0]               run_waddr;
  alrle_pkg::run_entry_t       run_wdata;
  logic                        rd_en;
  logic [AW-1:0]               pix_raddr;
  logic [AW-1:0]               run_raddr;
  logic [alrle_pkg::RGB_W-1:0] pix_rdata;
  alrle_pkg::run_entry_t       run_rdata;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;
  assign cfg_sel   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width  <= alrle_pkg::ROW_WIDTH_RESET;
      key_enable <= 1'b0;
      key_colour <= '0;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        alrle_pkg::REG_ROW_WIDTH:  row_width  <= pwdata[15:0];
        alrle_pkg::REG_KEY_ENABLE: key_enable <= pwdata[0];
        alrle_pkg::REG_KEY_COLOUR: key_colour <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      alrle_pkg::REG_ROW_WIDTH:  prdata = {16'd0, row_width};
      alrle_pkg::REG_KEY_ENABLE: prdata = {31'd0, key_enable};
      alrle_pkg::REG_KEY_COLOUR: prdata = {16'd0, key_colour};
      default:                   prdata = '0;
    endcase
  end

  always_comb begin
    cfg.row_width  = row_width;
    cfg.key_enable = key_enable;
    cfg.key_colour = key_colour;
    cfg.restart    = cfg_write && (cfg_sel == alrle_pkg::REG_ROW_WIDTH);
    cfg.new_width  = pwdata[15:0];
  end

  alrle_front #(
    .SEGMENT_WIDTH(SEGMENT_WIDTH),
    .AW(AW)
  ) u_front (
    .clk(clk),
    .rst(rst),
    .pixels(pixels),
    .cfg(cfg),
    .rel(rel),
    .desc(desc_in),
    .desc_push(desc_push),
    .pix_we(pix_we),
    .pix_waddr(pix_waddr),
    .pix_wdata(pix_wdata),
    .run_we(run_we),
    .run_waddr(run_waddr),
    .run_wdata(run_wdata)
  );

  alrle_desc_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(desc_push),
    .din(desc_in),
    .pop(desc_pop),
    .dout(desc_out),
    .empty(desc_empty)
  );

  alrle_ram #(
    .WIDTH(alrle_pkg::RGB_W),
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_pix_ram (
    .clk(clk),
    .we(pix_we),
    .waddr(pix_waddr),
    .wdata(pix_wdata),
    .re(rd_en),
    .raddr(pix_raddr),
    .rdata(pix_rdata)
  );

  alrle_ram #(
    .WIDTH($bits(alrle_pkg::run_entry_t)),
    .DEPTH(DEPTH),
    .AW(AW)
  ) u_run_ram (
    .clk(clk),
    .we(run_we),
    .waddr(run_waddr),
    .wdata(run_wdata),
    .re(rd_en),
    .raddr(run_raddr),
    .rdata(run_rdata)
  );

  alrle_back #(
    .SEGMENT_WIDTH(SEGMENT_WIDTH),
    .AW(AW)
  ) u_back (
    .clk(clk),
    .rst(rst),
    .desc(desc_out),
    .desc_empty(desc_empty),
    .desc_pop(desc_pop),
    .rel(rel),
    .rd_en(rd_en),
    .pix_raddr(pix_raddr),
    .run_raddr(run_raddr),
    .pix_rdata(pix_rdata),
    .run_rdata(run_rdata),
    .words(words)
  );

endmodule

>>> design/alrle_checker.sv
module alrle_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] code_word,
  input logic [17:0] segment_offset,
  input logic [31:0] coloured_total,
  input logic        segment_last
);

  logic        out_accept;
  logic        seg_start;
  logic [31:0] last_total;

  assign out_accept = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_start  <= 1'b1;
      last_total <= '0;
    end else if (out_accept) begin
      seg_start  <= segment_last;
      last_total <= coloured_total;
    end
  end

  // a stalled word holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_word)
      && $stable(segment_offset) && $stable(coloured_total) && $stable(segment_last))
    else $error("stalled output word changed");

  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  assert property (@(posedge clk) disable iff (rst)
    out_accept |-> coloured_total >= last_total)
    else $error("coloured count went backward");

  // every segment opens with a nonzero run count
  assert property (@(posedge clk) disable iff (rst)
    out_accept && seg_start |-> code_word != 16'd0
      && code_word < 16'(1 << alrle_pkg::RUN_W) && !segment_last)
    else $error("segment does not open with a run count");

endmodule

bind alpha_level_run_length_encoder_top alrle_checker u_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(words.valid),
  .out_ready(words.ready),
  .code_word(words.code_word),
  .segment_offset(words.segment_offset),
  .coloured_total(words.coloured_total),
  .segment_last(words.segment_last)
);

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int CLK_PERIOD    = 10;
  localparam int SEGMENT_WIDTH = 16;
  localparam int SETTLE_CYCLES = 10;
  localparam int CYCLE_LIMIT   = 500000;

  localparam logic [3:0] ADDR_ROW_WIDTH  = {alrle_pkg::REG_ROW_WIDTH, 2'b00};
  localparam logic [3:0] ADDR_KEY_ENABLE = {alrle_pkg::REG_KEY_ENABLE, 2'b00};
  localparam logic [3:0] ADDR_KEY_COLOUR = {alrle_pkg::REG_KEY_COLOUR, 2'b00};
  localparam logic [3:0] ADDR_UNMAPPED   = 4'd12;

  typedef struct packed {
    logic [15:0] code;
    logic [17:0] offset;
    logic [31:0] total;
    logic        last;
  } rle_word_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  alrle_pixel_if pix_if ();
  alrle_word_if  word_if ();

  alpha_level_run_length_encoder_top #(.SEGMENT_WIDTH(SEGMENT_WIDTH)) u_dut (
    .clk     (clk),
    .rst     (rst),
    .pixels  (pix_if),
    .words   (word_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // encoder state as seen from outside
  logic [15:0] row_width;
  logic        key_on;
  logic [15:0] key_rgb;
  logic [2:0]  seg_level [SEGMENT_WIDTH];
  logic [15:0] seg_rgb [SEGMENT_WIDTH];
  int          seg_fill;
  logic [15:0] row_pos;
  logic [17:0] row_off;
  logic [31:0] coloured_count;

  rle_word_t pending_words [$];

  int          send_idle_pct;
  int          ready_stall_pct;
  int          errors;
  int          pixels_sent;
  int          words_checked;
  int          segments_closed;
  int          settings_used;
  int          cycle_count;
  logic [7:0]  cur_alpha;

  function automatic int active_width();
    return (row_width == 16'd0) ? 1 : int'(row_width);
  endfunction

  function automatic int column_count();
    return (active_width() + SEGMENT_WIDTH - 1) / SEGMENT_WIDTH;
  endfunction

  function automatic logic [2:0] quantize_alpha(input logic [7:0] a);
    if (a < 8'd32) return 3'd0;
    if (a < 8'd96) return 3'd1;
    if (a < 8'd160) return 3'd2;
    if (a < 8'd224) return 3'd3;
    return 3'd4;
  endfunction

  function automatic void clear_encoder();
    row_width = alrle_pkg::ROW_WIDTH_RESET;
    key_on = 1'b0;
    key_rgb = 16'd0;
    seg_fill = 0;
    row_pos = 16'd0;
    coloured_count = 32'd0;
    row_off = 18'(column_count());
  endfunction

  function automatic void apply_register(input logic [3:0] addr, input logic [31:0] data);
    case (addr)
      ADDR_ROW_WIDTH: begin
        row_width = data[15:0];
        row_pos = 16'd0;
        seg_fill = 0;
        row_off = 18'(column_count());
      end
      ADDR_KEY_ENABLE: key_on = data[0];
      ADDR_KEY_COLOUR: key_rgb = data[15:0];
      default: ;
    endcase
  endfunction

  function automatic void push_word(input logic [15:0] code, input logic [17:0] off,
                                    input bit last);
    rle_word_t w;
    w.code = code;
    w.offset = off;
    w.total = coloured_count;
    w.last = last;
    pending_words.push_back(w);
  endfunction

  // gather one pixel; on a segment or row close, queue its words
  function automatic void encode_pixel(input logic [31:0] px);
    logic [7:0]  alpha;
    logic [15:0] rgb;
    logic [17:0] off;
    bit          row_end;
    int          n, runs, total, i, j, k, len;
    alpha = px[31:24];
    rgb = {px[7:3], px[15:10], px[23:19]};
    if (key_on && rgb == key_rgb) begin
      alpha = 8'd0;
      rgb = 16'd0;
    end
    if (seg_fill >= SEGMENT_WIDTH) seg_fill = 0;
    seg_level[seg_fill] = quantize_alpha(alpha);
    seg_rgb[seg_fill] = rgb;
    seg_fill++;
    row_pos = row_pos + 16'd1;
    row_end = int'(row_pos) >= active_width();
    if (seg_fill < SEGMENT_WIDTH && !row_end) return;

    n = seg_fill;
    runs = 0;
    total = 1;
    for (i = 0; i < n; i++) begin
      if (i == 0 || seg_level[i] != seg_level[i-1]) runs++;
      if (seg_level[i] != 3'd0) total++;
    end
    total += runs;
    off = row_off;
    k = 0;
    push_word(16'(runs), off, total == 1);
    k++;
    i = 0;
    while (i < n) begin
      len = 1;
      while (i + len < n && seg_level[i+len] == seg_level[i]) len++;
      push_word({seg_level[i], 13'(len)}, off, k + 1 == total);
      k++;
      if (seg_level[i] != 3'd0) begin
        for (j = 0; j < len; j++) begin
          if (coloured_count != 32'hFFFF_FFFF) coloured_count++;
          push_word(seg_rgb[i+j], off, k + 1 == total);
          k++;
        end
      end
      i += len;
    end
    seg_fill = 0;
    segments_closed++;
    if (row_end) begin
      row_pos = 16'd0;
      row_off = 18'(column_count());
    end else begin
      row_off = row_off + 18'(total);
    end
  endfunction

  function automatic logic [7:0] alpha_edge(input int idx);
    case (idx)
      0: return 8'd0;
      1: return 8'd31;
      2: return 8'd32;
      3: return 8'd95;
      4: return 8'd96;
      5: return 8'd159;
      6: return 8'd160;
      7: return 8'd223;
      8: return 8'd224;
      default: return 8'd255;
    endcase
  endfunction

  // keep the alpha sticky so that runs grow long
  function automatic logic [31:0] random_pixel();
    logic [31:0] px;
    px = $urandom;
    if ($urandom_range(99) < 30) begin
      if ($urandom_range(1) == 0) cur_alpha = alpha_edge($urandom_range(9));
      else cur_alpha = 8'($urandom);
    end
    px[31:24] = cur_alpha;
    if ($urandom_range(99) < 20) begin
      px[7:0]   = {key_rgb[15:11], 3'($urandom)};
      px[15:8]  = {key_rgb[10:5], 2'($urandom)};
      px[23:16] = {key_rgb[4:0], 3'($urandom)};
    end
    return px;
  endfunction

  // called and returns at a falling edge; valid stays high after the pixel
  task automatic send_pixel(input logic [31:0] px);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_if.valid <= 1'b0;
      @(negedge clk);
    end
    pix_if.valid <= 1'b1;
    pix_if.pixel_abgr <= px;
    @(posedge clk);
    while (!pix_if.ready) @(posedge clk);
    encode_pixel(px);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic drain_words();
    pix_if.valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [3:0] addr, input logic [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    apply_register(addr, data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_random_settings();
    logic [15:0] width;
    logic [15:0] key;
    case ($urandom_range(9))
      0: width = 16'd1;
      1: width = 16'd16;
      2: width = 16'd65535;
      3: width = 16'd0;
      default: width = 16'($urandom_range(40, 2));
    endcase
    case ($urandom_range(2))
      0: key = 16'h0000;
      1: key = 16'hFFFF;
      default: key = 16'($urandom);
    endcase
    write_register(ADDR_ROW_WIDTH, {16'($urandom), width});
    write_register(ADDR_KEY_ENABLE, {31'($urandom), 1'($urandom)});
    write_register(ADDR_KEY_COLOUR, {16'($urandom), key});
    settings_used++;
  endtask

  // every level boundary at the reset width; one full segment
  task automatic test_alpha_levels();
    int i;
    send_idle_pct = 0;
    ready_stall_pct = 0;
    for (i = 0; i < 10; i++) send_pixel({alpha_edge(i), 24'(i * 24'h1A2B3C)});
    send_pixel(32'h0000_0000);
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hFF00_0000);
    send_pixel(32'hE0F8_FCF8);
    send_pixel(32'h6007_0307);
    send_pixel(32'h1FFF_FFFF);
    drain_words();
  endtask

  task automatic test_zero_width();
    write_register(ADDR_ROW_WIDTH, 32'hFFFF_0000);
    settings_used++;
    send_pixel(32'hFF12_3456);
    send_pixel(32'h00AB_CDEF);
    drain_words();
  endtask

  task automatic test_colour_key();
    write_register(ADDR_ROW_WIDTH, 32'd3);
    write_register(ADDR_KEY_ENABLE, 32'hFFFF_FFFF);
    write_register(ADDR_KEY_COLOUR, 32'hFFFF_FFFF);
    settings_used++;
    send_pixel(32'hFFFF_FFFF);
    send_pixel(32'hFFF8_FCF8);
    send_pixel(32'hFFF7_FFFF);
    drain_words();
    write_register(ADDR_KEY_COLOUR, 32'h0000_0000);
    // must not disturb any register
    write_register(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    settings_used++;
    send_pixel(32'hFF07_0307);
    send_pixel(32'hFF08_0000);
    send_pixel(32'h4000_0000);
    drain_words();
  endtask

  // widest row, then a width write drops the partly gathered segment
  task automatic test_width_restart();
    int i;
    write_register(ADDR_ROW_WIDTH, 32'h0000_FFFF);
    write_register(ADDR_KEY_ENABLE, 32'd0);
    settings_used++;
    for (i = 0; i < SEGMENT_WIDTH + 1; i++) send_pixel(random_pixel());
    drain_words();
    write_register(ADDR_ROW_WIDTH, 32'd2);
    settings_used++;
    send_pixel(32'h8012_3456);
    send_pixel(32'hC0FE_DCBA);
    drain_words();
  endtask

  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input bit hold_midway);
    int s, p;
    send_idle_pct = idle_pct;
    ready_stall_pct = stall_pct;
    for (s = 0; s < 3; s++) begin
      program_random_settings();
      for (p = 0; p < 11; p++) begin
        if (hold_midway && p == 7) drain_words();
        send_pixel(random_pixel());
      end
      drain_words();
    end
  endtask

  always @(negedge clk) begin
    word_if.ready <= ($urandom_range(99) >= ready_stall_pct);
  end

  always @(posedge clk) begin
    rle_word_t want;
    if (!rst && word_if.valid && word_if.ready) begin
      words_checked++;
      if (pending_words.size() == 0) begin
        $error("unexpected word: code_word %h, segment_offset %0d",
               word_if.code_word, word_if.segment_offset);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (word_if.code_word !== want.code) begin
          $error("code_word: expected %h, actual %h", want.code, word_if.code_word);
          errors++;
        end
        if (word_if.segment_offset !== want.offset) begin
          $error("segment_offset: expected %0d, actual %0d",
                 want.offset, word_if.segment_offset);
          errors++;
        end
        if (word_if.coloured_total !== want.total) begin
          $error("coloured_total: expected %0d, actual %0d",
                 want.total, word_if.coloured_total);
          errors++;
        end
        if (word_if.segment_last !== want.last) begin
          $error("segment_last: expected %b, actual %b", want.last, word_if.segment_last);
          errors++;
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'd0;
    pwdata = 32'd0;
    pix_if.valid = 1'b0;
    pix_if.pixel_abgr = 32'd0;
    word_if.ready = 1'b0;
    send_idle_pct = 0;
    ready_stall_pct = 0;
    errors = 0;
    pixels_sent = 0;
    words_checked = 0;
    segments_closed = 0;
    settings_used = 1;
    cur_alpha = 8'd255;
    clear_encoder();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (4) @(negedge clk);

    test_alpha_levels();
    test_zero_width();
    test_colour_key();
    test_width_restart();
    test_random_phase(0, 0, 1'b1);
    test_random_phase(86, 0, 1'b0);
    test_random_phase(0, 86, 1'b0);
    test_random_phase(29, 29, 1'b0);

    drain_words();
    if (pending_words.size() != 0) begin
      $error("%0d expected words never arrived", pending_words.size());
      errors++;
    end
    $display("Encoded %0d pixels into %0d segments, %0d words checked,",
             pixels_sent, segments_closed, words_checked);
    $display("across %0d register settings and four idle/stall mixes.", settings_used);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> sim.f
design/alrle_pkg.sv
design/alrle_if.sv
design/alrle_ram.sv
design/alrle_front.sv
design/alrle_desc_queue.sv
design/alrle_back.sv
design/alpha_level_run_length_encoder_top.sv
design/alrle_checker.sv
test/tb_top.sv
